[design/lafl_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lafl_pkg
// Shared widths, constants, segment tables and types for the light sensor
// to lux converter.
// -----------------------------------------------------------------------------
package lafl_pkg;

   // field widths
   localparam int ADC_W      = 12;
   localparam int LUX_W      = 27;
   localparam int OUT_CNT_W  = 4;

   // brightness ratio, unsigned Q0.16 plus one integer bit for 1.0
   localparam int RATIO_W      = 17;
   localparam int RATIO_FRAC_W = 16;

   // divider remainder / divisor width (ratio denominators and window counts)
   localparam int DEN_W = 12;

   localparam logic [ADC_W-1:0]   ADC_FULL  = 12'd4095;
   localparam logic [RATIO_W-1:0] RATIO_ONE = 17'd65536;
   localparam logic [LUX_W-1:0]   LUX_MAX   = 27'd102400000;
   localparam logic [LUX_W-1:0]   LUX_MIN   = 27'd1;

   // segment tables: threshold (Q0.16), base and slope in lux x100
   localparam int SEG_N   = 7;
   localparam int BASE_W  = 20;
   localparam int SLOPE_W = 28;
   localparam logic [RATIO_W-1:0] SEG_THR [SEG_N] = '{
      17'd0, 17'd6554, 17'd19661, 17'd32768, 17'd45875, 17'd55706, 17'd62259
   };
   localparam logic [BASE_W-1:0] SEG_BASE [SEG_N] = '{
      20'd0, 20'd30, 20'd1000, 20'd5000, 20'd50000, 20'd100000, 20'd1000000
   };
   localparam logic [SLOPE_W-1:0] SEG_SLOPE [SEG_N] = '{
      28'd300, 28'd4850, 28'd20000, 28'd225000, 28'd333333, 28'd9000000,
      28'd180000000
   };

   // segment arithmetic widths: the widest offset within a segment is 13107
   localparam int DIFF_W     = 14;
   localparam int PROD_W     = DIFF_W + SLOPE_W;
   localparam int NUM_W      = 40;
   // divide by 6400 = shift by 8, then multiply by a reciprocal of 25
   localparam int LUX_SHIFT  = 8;
   localparam int X_W        = NUM_W - LUX_SHIFT;
   localparam int RECIP_W    = 31;
   localparam logic [RECIP_W-1:0] RECIP_25 = 31'd1374389535;
   localparam int RECIP_SHIFT = 35;
   localparam int Y_W        = X_W + RECIP_W;
   localparam int Q_W        = Y_W - RECIP_SHIFT;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIBRATED    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DARK_LEVEL    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHT_LEVEL  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ENABLE = 2'd3;

   localparam int WINDOW_DEPTH_DEF = 8;

   // per-cell window control
   typedef struct packed {
      logic wr;    // store the new instant value in this cell
      logic sel;   // cell lies inside the current averaging count
   } cell_ctrl_type;

endpackage

[design/light_adc_to_filtered_lux.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// light_adc_to_filtered_lux
// Photoresistor sample to lux (1/1024 units) with optional moving average.
//
// req_* carries one 12-bit ADC sample per transaction; rsp_* returns the
// filtered lux, the instant lux and the number of entries averaged. csr_*
// writes calibrated, dark_level, bright_level and filter_enable (indices
// 0..3); writing 0 to filter_enable empties the window.
// One sample is processed at a time. With the filter off, an accepted sample
// runs through the segment pipeline, after the 16-step divider when the
// calibrated ratio needs it; samples of 0 and full scale skip both. The
// filter adds the window sum passing down the cell chain and then the
// one-bit-per-cycle average divider. The next sample can be taken in the
// same cycle that rsp_valid rises.
// The result sits in an output register, so the next sample is accepted
// while it waits; a stalled receiver holds the following result back, and
// with it the input.
// Reset (synchronous) empties the window, clears calibrated, dark_level and
// bright_level and sets filter_enable.
module light_adc_to_filtered_lux #(
   parameter int WINDOW_DEPTH = lafl_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lafl_pkg::ADC_W-1:0]        req_adc_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lafl_pkg::LUX_W-1:0]        rsp_lux_out,
   output logic [lafl_pkg::LUX_W-1:0]        rsp_instant_lux,
   output logic [lafl_pkg::OUT_CNT_W-1:0]    rsp_samples_averaged,
   input  logic                              csr_write_enable,
   input  logic [lafl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lafl_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import lafl_pkg::*;

   localparam int SUM_W  = LUX_W + $clog2(WINDOW_DEPTH);
   localparam int STEP_W = $clog2(SUM_W+1);
   localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNTI_W = $clog2(WINDOW_DEPTH+1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RATIO = 3'd1;
   localparam logic [2:0] S_MAPGO = 3'd2;
   localparam logic [2:0] S_MAP   = 3'd3;
   localparam logic [2:0] S_WIN   = 3'd4;
   localparam logic [2:0] S_SUM   = 3'd5;
   localparam logic [2:0] S_AVGGO = 3'd6;
   localparam logic [2:0] S_AVGW  = 3'd7;

   // config
   logic              cal_ff;
   logic [ADC_W-1:0]  dark_ff;
   logic [ADC_W-1:0]  bright_ff;
   logic              filt_ff;

   // control
   logic [2:0]        state_ff;
   logic              done_pend_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              full_ff;
   logic [CNTI_W-1:0] count_ff;
   logic [CNTI_W-1:0] tmr_ff;

   // payload
   logic [RATIO_W-1:0] r_ff;
   logic [LUX_W-1:0]   inst_ff;
   logic [LUX_W-1:0]   avg_ff;

   logic               rsp_valid_ff;
   logic [LUX_W-1:0]   rsp_lux_ff;
   logic [LUX_W-1:0]   rsp_inst_ff;
   logic [OUT_CNT_W-1:0] rsp_cnt_ff;

   logic               req_accept;
   logic               out_free;

   // ratio set-up
   logic               cal_ok;
   logic [ADC_W-1:0]   cal_den;
   logic [ADC_W-1:0]   cal_num;
   logic [ADC_W-1:0]   uncal_num;
   logic [RATIO_W-1:0] uncal_x16;
   logic [RATIO_W-1:0] uncal_fix;
   logic [RATIO_W-1:0] uncal_ratio;
   logic               need_div;
   logic [DEN_W-1:0]   ratio_rem;
   logic [DEN_W-1:0]   ratio_den;

   // divider
   logic               div_start;
   logic [DEN_W-1:0]   div_rem_init;
   logic [SUM_W-1:0]   div_dvd;
   logic [DEN_W-1:0]   div_den;
   logic [STEP_W-1:0]  div_steps;
   logic               div_busy;
   logic               div_done;
   logic [SUM_W-1:0]   div_quot;

   // segment map
   logic               map_done;
   logic [LUX_W-1:0]   map_lux;

   // window
   logic [SLOT_W-1:0]  slot_in;
   logic               wrap;
   logic               full_in;
   logic [CNTI_W-1:0]  count_in;
   logic [CNTI_W+OUT_CNT_W-1:0] count_wide;
   cell_ctrl_type      cell_ctrl [WINDOW_DEPTH];
   logic [SUM_W-1:0]   chain_in  [WINDOW_DEPTH];
   logic [SUM_W-1:0]   cell_sum  [WINDOW_DEPTH];

   assign req_ready  = (state_ff == S_IDLE) && !done_pend_ff;
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cal_ok      = cal_ff && (dark_ff > bright_ff);
      cal_den     = dark_ff - bright_ff;
      cal_num     = dark_ff - req_adc_sample;
      // 65536 / 4095 = 16 + 16 / 4095; the fraction is a divide by 2^12 - 1
      uncal_num   = ADC_FULL - req_adc_sample;
      uncal_x16   = RATIO_W'(uncal_num) << (RATIO_FRAC_W - ADC_W);
      uncal_fix   = uncal_x16 + (uncal_x16 >> ADC_W) + RATIO_W'(1);
      uncal_ratio = uncal_x16 + (uncal_fix >> ADC_W);
      ratio_rem   = cal_num;
      ratio_den   = cal_den;
      need_div    = cal_ok && (req_adc_sample < dark_ff) && (cal_num < cal_den);
      if ((req_adc_sample == '0) || (req_adc_sample == ADC_FULL)) begin
         need_div = 1'b0;
      end
   end

   always_comb begin
      div_start    = (req_accept && need_div) || (state_ff == S_AVGGO);
      div_rem_init = ratio_rem;
      div_dvd      = '0;
      div_den      = ratio_den;
      div_steps    = STEP_W'(RATIO_FRAC_W);
      if (state_ff == S_AVGGO) begin
         div_rem_init = '0;
         div_dvd      = cell_sum[WINDOW_DEPTH-1];
         div_den      = DEN_W'(count_ff);
         div_steps    = STEP_W'(SUM_W);
      end
   end

   lafl_div #(
      .DVD_W (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem_init),
      .dvd      (div_dvd),
      .den      (div_den),
      .steps    (div_steps),
      .busy     (div_busy),
      .done     (div_done),
      .quot     (div_quot)
   );

   lafl_lux_map u_map (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_MAPGO),
      .ratio (r_ff),
      .done  (map_done),
      .lux   (map_lux)
   );

   // window slot bookkeeping
   always_comb begin
      wrap     = (slot_ff == SLOT_W'(WINDOW_DEPTH-1));
      slot_in  = wrap ? '0 : slot_ff + SLOT_W'(1);
      full_in  = full_ff || wrap;
      count_in = full_in ? CNTI_W'(WINDOW_DEPTH) : CNTI_W'(slot_in);
      count_wide = {{OUT_CNT_W{1'b0}}, count_ff};
   end

   genvar g;
   generate
      for (g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
         if (g == 0) begin : g_head
            assign chain_in[g] = '0;
         end else begin : g_link
            assign chain_in[g] = cell_sum[g-1];
         end
         assign cell_ctrl[g].wr  = (state_ff == S_WIN) && filt_ff &&
                                   (slot_ff == SLOT_W'(g));
         assign cell_ctrl[g].sel = (count_ff > CNTI_W'(g));
         lafl_cell #(
            .SUM_W (SUM_W)
         ) u_cell (
            .clock   (clock),
            .ctrl    (cell_ctrl[g]),
            .wr_data (inst_ff),
            .sum_in  (chain_in[g]),
            .sum_out (cell_sum[g])
         );
      end
   endgenerate

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         done_pend_ff <= 1'b0;
         slot_ff      <= '0;
         full_ff      <= 1'b0;
         cal_ff       <= 1'b0;
         dark_ff      <= '0;
         bright_ff    <= '0;
         filt_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // finished result moves into the output register once it is free
         if (done_pend_ff && out_free) begin
            done_pend_ff <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  if (req_adc_sample == '0) begin
                     state_ff <= S_WIN;
                  end else if (req_adc_sample == ADC_FULL) begin
                     state_ff <= S_WIN;
                  end else if (need_div) begin
                     state_ff <= S_RATIO;
                  end else begin
                     state_ff <= S_MAPGO;
                  end
               end
            end
            S_RATIO: begin
               if (div_done) begin
                  state_ff <= S_MAPGO;
               end
            end
            S_MAPGO: state_ff <= S_MAP;
            S_MAP: begin
               if (map_done) begin
                  state_ff <= S_WIN;
               end
            end
            S_WIN: begin
               if (filt_ff) begin
                  slot_ff  <= slot_in;
                  full_ff  <= full_in;
                  state_ff <= S_SUM;
               end else begin
                  done_pend_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_SUM: begin
               if (tmr_ff == '0) begin
                  state_ff <= S_AVGGO;
               end
            end
            S_AVGGO: state_ff <= S_AVGW;
            S_AVGW: begin
               if (div_done) begin
                  done_pend_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_CALIBRATED:   cal_ff    <= csr_write_data[0];
               CSR_DARK_LEVEL:   dark_ff   <= csr_write_data[ADC_W-1:0];
               CSR_BRIGHT_LEVEL: bright_ff <= csr_write_data[ADC_W-1:0];
               CSR_FILTER_ENABLE: begin
                  filt_ff <= csr_write_data[0];
                  if (!csr_write_data[0]) begin
                     slot_ff <= '0;
                     full_ff <= 1'b0;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (req_adc_sample == '0) begin
            inst_ff <= LUX_MAX;
         end else if (req_adc_sample == ADC_FULL) begin
            inst_ff <= LUX_MIN;
         end
         if (!cal_ok) begin
            r_ff <= uncal_ratio;
         end else if (req_adc_sample >= dark_ff) begin
            r_ff <= '0;
         end else begin
            r_ff <= RATIO_ONE;
         end
      end
      if ((state_ff == S_RATIO) && div_done) begin
         r_ff <= RATIO_W'(div_quot[RATIO_FRAC_W-1:0]);
      end
      if ((state_ff == S_MAP) && map_done) begin
         inst_ff <= map_lux;
      end
      if (state_ff == S_WIN) begin
         count_ff <= count_in;
         tmr_ff   <= CNTI_W'(WINDOW_DEPTH-1);
      end else if (state_ff == S_SUM) begin
         tmr_ff <= tmr_ff - CNTI_W'(1);
      end
      if ((state_ff == S_AVGW) && div_done) begin
         avg_ff <= div_quot[LUX_W-1:0];
      end
      if (done_pend_ff && out_free) begin
         rsp_inst_ff <= inst_ff;
         if (filt_ff) begin
            rsp_lux_ff <= avg_ff;
            rsp_cnt_ff <= count_wide[OUT_CNT_W-1:0];
         end else begin
            rsp_lux_ff <= inst_ff;
            rsp_cnt_ff <= OUT_CNT_W'(1);
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_lux_out          = rsp_lux_ff;
   assign rsp_instant_lux      = rsp_inst_ff;
   assign rsp_samples_averaged = rsp_cnt_ff;

`ifndef NO_ASSERTIONS
   // a new sample never arrives while the divider is still working
   a_ready_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_busy)
      else $error("sample accepted while divider busy");

   // divider results only land in the two states that wait for them
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((state_ff == S_RATIO) || (state_ff == S_AVGW)))
      else $error("divider finished outside a waiting state");

   // segment pipeline result only returns while the sequencer waits for it
   a_map_done_state: assert property (@(posedge clock) disable iff (reset)
      map_done |-> (state_ff == S_MAP))
      else $error("segment result outside map wait");

   // averaging count is never zero and never beyond the window
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_AVGGO) |->
         ((count_ff != '0) && (count_ff <= CNTI_W'(WINDOW_DEPTH))))
      else $error("window count out of range");
`endif

endmodule

[design/lafl_div.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lafl_div
// Restoring divider, one quotient bit per cycle, with a preloadable partial
// remainder and a programmable number of steps.
// -----------------------------------------------------------------------------
module lafl_div #(
   parameter int DVD_W = 30
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [lafl_pkg::DEN_W-1:0]          rem_init,
   input  logic [DVD_W-1:0]                    dvd,
   input  logic [lafl_pkg::DEN_W-1:0]          den,
   input  logic [$clog2(DVD_W+1)-1:0]          steps,
   output logic                                busy,
   output logic                                done,
   output logic [DVD_W-1:0]                    quot
);
   import lafl_pkg::*;

   localparam int STEP_W = $clog2(DVD_W+1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  rem_in;
   logic [DEN_W-1:0]  den_ff;
   logic [DVD_W-1:0]  dq_ff;
   logic [DEN_W:0]    trial;
   logic              qbit;

   // remainder stays below the divisor, so the trial fits one extra bit
   always_comb begin
      trial = {rem_ff, dq_ff[DVD_W-1]};
      qbit  = (trial >= {1'b0, den_ff});
      if (qbit) begin
         rem_in = DEN_W'(trial - {1'b0, den_ff});
      end else begin
         rem_in = trial[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == STEP_W'(1))) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= rem_init;
         den_ff <= den;
         dq_ff  <= dvd;
         cnt_ff <= steps;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dq_ff  <= {dq_ff[DVD_W-2:0], qbit};
         cnt_ff <= cnt_ff - STEP_W'(1);
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = dq_ff;

endmodule

[design/lafl_lux_map.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lafl_lux_map
// Five-stage pipeline mapping a Q0.16 brightness ratio through the seven
// linear segments to lux in 1/1024 units, clamped.
// -----------------------------------------------------------------------------
module lafl_lux_map (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lafl_pkg::RATIO_W-1:0]  ratio,
   output logic                          done,
   output logic [lafl_pkg::LUX_W-1:0]    lux
);
   import lafl_pkg::*;

   logic [4:0]         vld_ff;
   logic [DIFF_W-1:0]  diff_ff;
   logic [BASE_W-1:0]  base_ff;
   logic [BASE_W-1:0]  base2_ff;
   logic [SLOPE_W-1:0] slope_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [X_W-1:0]     x_ff;
   logic [Y_W-1:0]     y_ff;
   logic [LUX_W-1:0]   lux_ff;

   logic [RATIO_W-1:0] thr_sel;
   logic [BASE_W-1:0]  base_sel;
   logic [SLOPE_W-1:0] slope_sel;
   logic [NUM_W-1:0]   num;
   logic [Q_W-1:0]     q;

   // last segment whose threshold is not above the ratio
   always_comb begin
      thr_sel   = SEG_THR[0];
      base_sel  = SEG_BASE[0];
      slope_sel = SEG_SLOPE[0];
      for (int i = 1; i < SEG_N; i++) begin
         if (ratio >= SEG_THR[i]) begin
            thr_sel   = SEG_THR[i];
            base_sel  = SEG_BASE[i];
            slope_sel = SEG_SLOPE[i];
         end
      end
   end

   assign num = NUM_W'({base2_ff, 16'd0}) + NUM_W'(prod_ff);
   assign q   = y_ff[Y_W-1:RECIP_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[3:0], start};
      end
   end

   always_ff @(posedge clock) begin
      diff_ff  <= DIFF_W'(ratio - thr_sel);
      base_ff  <= base_sel;
      slope_ff <= slope_sel;
      prod_ff  <= PROD_W'(diff_ff * slope_ff);
      base2_ff <= base_ff;
      x_ff     <= num[NUM_W-1:LUX_SHIFT];
      y_ff     <= Y_W'(x_ff * RECIP_25);
      if (q == '0) begin
         lux_ff <= LUX_MIN;
      end else if (q > Q_W'(LUX_MAX)) begin
         lux_ff <= LUX_MAX;
      end else begin
         lux_ff <= q[LUX_W-1:0];
      end
   end

   assign done = vld_ff[4];
   assign lux  = lux_ff;

endmodule

[design/lafl_cell.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lafl_cell
// One window entry with a registered partial sum; cells chain to form the
// moving-average accumulator.
// -----------------------------------------------------------------------------
module lafl_cell #(
   parameter int SUM_W = 30
) (
   input  logic                          clock,
   input  lafl_pkg::cell_ctrl_type       ctrl,
   input  logic [lafl_pkg::LUX_W-1:0]    wr_data,
   input  logic [SUM_W-1:0]              sum_in,
   output logic [SUM_W-1:0]              sum_out
);
   import lafl_pkg::*;

   logic [LUX_W-1:0] entry_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in_term;

   assign sum_in_term = ctrl.sel ? SUM_W'(entry_ff) : '0;

   always_ff @(posedge clock) begin
      if (ctrl.wr) begin
         entry_ff <= wr_data;
      end
      sum_ff <= sum_in + sum_in_term;
   end

   assign sum_out = sum_ff;

endmodule
